>>> src/linear_congruence_solver_macros.svh
// Assertion macros shared by the checker.
`ifndef LINEAR_CONGRUENCE_SOLVER_MACROS_SVH
`define LINEAR_CONGRUENCE_SOLVER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define LCS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define LCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/lcs_pkg.sv
package lcs_pkg;

   localparam int DEFAULT_WIDTH = 32;
   localparam int PORT_BITS     = 32;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TEST,
      S_EDIV,
      S_EMUL_START,
      S_EMUL,
      S_GDIV,
      S_GCHK,
      S_SMUL
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_EUCLID,
      OP_DIV_GCD,
      OP_DIV_STEP,
      OP_MUL_COEF,
      OP_MUL_SOL,
      OP_MUL_STEP,
      OP_EUCLID_UPDATE,
      OP_EMIT_FAIL,
      OP_EMIT_OK
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic m_zero;
      logic r_cur_zero;
      logic div_last;
      logic mul_done;
      logic rem_zero;
   } status_type;

endpackage

>>> src/lcs_ctrl.sv
module lcs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output lcs_pkg::cmd_type    cmd,
   input  lcs_pkg::status_type status
);

   lcs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.op   = lcs_pkg::OP_NONE;
      case (state_ff)
         lcs_pkg::S_IDLE: begin
            if (start) begin
               cmd.op   = lcs_pkg::OP_LOAD;
               state_in = lcs_pkg::S_TEST;
            end
         end
         lcs_pkg::S_TEST: begin
            if (status.m_zero) begin
               cmd.op   = lcs_pkg::OP_EMIT_FAIL;
               state_in = lcs_pkg::S_IDLE;
            end else if (status.r_cur_zero) begin
               cmd.op   = lcs_pkg::OP_DIV_GCD;
               state_in = lcs_pkg::S_GDIV;
            end else begin
               cmd.op   = lcs_pkg::OP_DIV_EUCLID;
               state_in = lcs_pkg::S_EDIV;
            end
         end
         lcs_pkg::S_EDIV: begin
            cmd.op = lcs_pkg::OP_DIV_STEP;
            if (status.div_last) begin
               state_in = lcs_pkg::S_EMUL_START;
            end
         end
         lcs_pkg::S_EMUL_START: begin
            cmd.op   = lcs_pkg::OP_MUL_COEF;
            state_in = lcs_pkg::S_EMUL;
         end
         lcs_pkg::S_EMUL: begin
            if (status.mul_done) begin
               cmd.op   = lcs_pkg::OP_EUCLID_UPDATE;
               state_in = lcs_pkg::S_TEST;
            end else begin
               cmd.op = lcs_pkg::OP_MUL_STEP;
            end
         end
         lcs_pkg::S_GDIV: begin
            cmd.op = lcs_pkg::OP_DIV_STEP;
            if (status.div_last) begin
               state_in = lcs_pkg::S_GCHK;
            end
         end
         lcs_pkg::S_GCHK: begin
            if (status.rem_zero) begin
               cmd.op   = lcs_pkg::OP_MUL_SOL;
               state_in = lcs_pkg::S_SMUL;
            end else begin
               cmd.op   = lcs_pkg::OP_EMIT_FAIL;
               state_in = lcs_pkg::S_IDLE;
            end
         end
         lcs_pkg::S_SMUL: begin
            if (status.mul_done) begin
               cmd.op   = lcs_pkg::OP_EMIT_OK;
               state_in = lcs_pkg::S_IDLE;
            end else begin
               cmd.op = lcs_pkg::OP_MUL_STEP;
            end
         end
         default: begin
            state_in = lcs_pkg::S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != lcs_pkg::S_IDLE);

endmodule

>>> src/lcs_dpath.sv
module lcs_dpath #(
   parameter int WIDTH = lcs_pkg::DEFAULT_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lcs_pkg::cmd_type               cmd,
   output lcs_pkg::status_type            status,
   input  logic                          csr_valid,
   input  logic [lcs_pkg::PORT_BITS-1:0] csr_data,
   input  logic [lcs_pkg::PORT_BITS-1:0] req_coefficient_a,
   input  logic [lcs_pkg::PORT_BITS-1:0] req_right_side_b,
   output logic                          rsp_valid,
   output logic [lcs_pkg::PORT_BITS-1:0] rsp_solution,
   output logic                          rsp_no_solution
);

   localparam int CNT_BITS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0] modulus_ff, modulus_in;
   logic [WIDTH-1:0] r_prev_ff, r_prev_in;
   logic [WIDTH-1:0] r_cur_ff, r_cur_in;
   logic [WIDTH-1:0] s_prev_ff, s_prev_in;
   logic [WIDTH-1:0] s_cur_ff, s_cur_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] term_ff, term_in;
   logic [WIDTH-1:0] mul_y_ff, mul_y_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [lcs_pkg::PORT_BITS-1:0] rsp_solution_ff, rsp_solution_in;
   logic rsp_no_solution_ff, rsp_no_solution_in;

   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   trial_diff;
   logic             trial_ge;
   logic [WIDTH:0]   acc_sum;
   logic [WIDTH-1:0] acc_red;
   logic [WIDTH:0]   term_sum;
   logic [WIDTH-1:0] term_red;
   logic [WIDTH-1:0] s_sub;
   logic [WIDTH-1:0] s_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= WIDTH'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_prev_ff          <= r_prev_in;
      r_cur_ff           <= r_cur_in;
      s_prev_ff          <= s_prev_in;
      s_cur_ff           <= s_cur_in;
      b_ff               <= b_in;
      rem_ff             <= rem_in;
      quo_ff             <= quo_in;
      dvs_ff             <= dvs_in;
      cnt_ff             <= cnt_in;
      acc_ff             <= acc_in;
      term_ff            <= term_in;
      mul_y_ff           <= mul_y_in;
      rsp_solution_ff    <= rsp_solution_in;
      rsp_no_solution_ff <= rsp_no_solution_in;
   end

   // restoring divider, one quotient bit per cycle
   assign trial      = {rem_ff, quo_ff[WIDTH-1]};
   assign trial_ge   = (trial >= {1'b0, dvs_ff});
   assign trial_diff = trial - {1'b0, dvs_ff};

   // double-and-add modular multiplier
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, term_ff};
   assign acc_red  = (acc_sum >= {1'b0, modulus_ff}) ?
                     WIDTH'(acc_sum - {1'b0, modulus_ff}) : acc_sum[WIDTH-1:0];
   assign term_sum = {term_ff, 1'b0};
   assign term_red = (term_sum >= {1'b0, modulus_ff}) ?
                     WIDTH'(term_sum - {1'b0, modulus_ff}) : term_sum[WIDTH-1:0];

   // coefficient update modulo m
   assign s_sub = s_prev_ff - acc_ff;
   assign s_new = (s_prev_ff < acc_ff) ? (s_sub + modulus_ff) : s_sub;

   always_comb begin
      modulus_in         = csr_valid ? WIDTH'(csr_data) : modulus_ff;
      r_prev_in          = r_prev_ff;
      r_cur_in           = r_cur_ff;
      s_prev_in          = s_prev_ff;
      s_cur_in           = s_cur_ff;
      b_in               = b_ff;
      rem_in             = rem_ff;
      quo_in             = quo_ff;
      dvs_in             = dvs_ff;
      cnt_in             = cnt_ff;
      acc_in             = acc_ff;
      term_in            = term_ff;
      mul_y_in           = mul_y_ff;
      rsp_valid_in       = 1'b0;
      rsp_solution_in    = rsp_solution_ff;
      rsp_no_solution_in = rsp_no_solution_ff;
      case (cmd.op)
         lcs_pkg::OP_LOAD: begin
            r_prev_in = WIDTH'(req_coefficient_a);
            r_cur_in  = modulus_ff;
            b_in      = WIDTH'(req_right_side_b);
            s_prev_in = WIDTH'(modulus_ff != WIDTH'(1));
            s_cur_in  = '0;
         end
         lcs_pkg::OP_DIV_EUCLID: begin
            quo_in = r_prev_ff;
            dvs_in = r_cur_ff;
            rem_in = '0;
            cnt_in = '0;
         end
         lcs_pkg::OP_DIV_GCD: begin
            quo_in = b_ff;
            dvs_in = r_prev_ff;
            rem_in = '0;
            cnt_in = '0;
         end
         lcs_pkg::OP_DIV_STEP: begin
            rem_in = trial_ge ? trial_diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], trial_ge};
            cnt_in = cnt_ff + CNT_BITS'(1);
         end
         lcs_pkg::OP_MUL_COEF: begin
            acc_in   = '0;
            term_in  = s_cur_ff;
            mul_y_in = quo_ff;
         end
         lcs_pkg::OP_MUL_SOL: begin
            acc_in   = '0;
            term_in  = s_prev_ff;
            mul_y_in = quo_ff;
         end
         lcs_pkg::OP_MUL_STEP: begin
            if (mul_y_ff[0]) begin
               acc_in = acc_red;
            end
            term_in  = term_red;
            mul_y_in = mul_y_ff >> 1;
         end
         lcs_pkg::OP_EUCLID_UPDATE: begin
            r_prev_in = r_cur_ff;
            r_cur_in  = rem_ff;
            s_prev_in = s_cur_ff;
            s_cur_in  = s_new;
         end
         lcs_pkg::OP_EMIT_FAIL: begin
            rsp_valid_in       = 1'b1;
            rsp_solution_in    = '0;
            rsp_no_solution_in = 1'b1;
         end
         lcs_pkg::OP_EMIT_OK: begin
            rsp_valid_in       = 1'b1;
            rsp_solution_in    = lcs_pkg::PORT_BITS'(acc_ff);
            rsp_no_solution_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign status.m_zero     = (modulus_ff == '0);
   assign status.r_cur_zero = (r_cur_ff == '0);
   assign status.div_last   = (cnt_ff == CNT_BITS'(WIDTH - 1));
   assign status.mul_done   = (mul_y_ff == '0);
   assign status.rem_zero   = (rem_ff == '0);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_solution    = rsp_solution_ff;
   assign rsp_no_solution = rsp_no_solution_ff;

endmodule

>>> src/linear_congruence_solver.sv
// Solves a*x = b (mod m) with m from the configuration register. Pulse start
// while busy is low to hand in a and b; busy rises on the next cycle and the
// result appears for exactly one cycle with rsp_valid, at the same edge that
// busy falls. The receiver cannot stall, so capture the result when the
// strobe is high. Each Euclid step runs a full division of the remainders
// and a modular multiply for the coefficient; a final division of b by the
// gcd and a multiply by b/gcd give the solution, with no multiply when gcd
// does not divide b. Busy time is set by the divider, which yields one
// quotient bit per cycle, and by the bit-serial modular multiplier. A zero
// modulus gives no_solution from the test state, with no division. Write
// csr_data only while busy is low; csr_ready is always high.
module linear_congruence_solver #(
   parameter int WIDTH = lcs_pkg::DEFAULT_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lcs_pkg::PORT_BITS-1:0] req_coefficient_a,
   input  logic [lcs_pkg::PORT_BITS-1:0] req_right_side_b,
   output logic                          rsp_valid,
   output logic [lcs_pkg::PORT_BITS-1:0] rsp_solution,
   output logic                          rsp_no_solution,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lcs_pkg::PORT_BITS-1:0] csr_data
);

   lcs_pkg::cmd_type    cmd;
   lcs_pkg::status_type status;

   assign csr_ready = 1'b1;

   lcs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   lcs_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_valid),
      .csr_data          (csr_data),
      .req_coefficient_a (req_coefficient_a),
      .req_right_side_b  (req_right_side_b),
      .rsp_valid         (rsp_valid),
      .rsp_solution      (rsp_solution),
      .rsp_no_solution   (rsp_no_solution)
   );

endmodule

>>> src/lcs_checker.sv
`include "linear_congruence_solver_macros.svh"

module lcs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [lcs_pkg::PORT_BITS-1:0] rsp_solution,
   input logic                          rsp_no_solution
);

   `LCS_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `LCS_ASSERT_NOW(a_fail_zero, rsp_valid && rsp_no_solution, rsp_solution == '0, "nonzero solution with no_solution set")
   `LCS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted beat did not raise busy")
   `LCS_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy, "result beat while still busy")

endmodule

bind linear_congruence_solver lcs_checker u_lcs_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_solution    (rsp_solution),
   .rsp_no_solution (rsp_no_solution)
);

>>> verif/linear_congruence_solver_tb.sv
`timescale 1ns / 1ps

module linear_congruence_solver_tb;

   localparam int          WORD_BITS       = lcs_pkg::PORT_BITS;
   localparam int          DUT_WIDTH       = lcs_pkg::DEFAULT_WIDTH;
   localparam logic [63:0] OPERAND_MASK    = (64'd1 << DUT_WIDTH) - 64'd1;
   localparam int          WATCHDOG_LIMIT  = 20000;
   localparam int          DRAIN_CYCLES    = 40;
   localparam int          RANDOM_PHASES   = 12;
   localparam logic [31:0] LARGEST_PRIME   = 32'hFFFF_FFFB;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      word_type solution;
      logic     no_solution;
   } solution_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   word_type req_coefficient_a = '0;
   word_type req_right_side_b = '0;
   logic     rsp_valid;
   word_type rsp_solution;
   logic     rsp_no_solution;
   logic     csr_valid = 1'b0;
   logic     csr_ready;
   word_type csr_data = '0;

   solution_type pending_solutions[$];
   word_type     modulus_shadow = word_type'(1);
   bit           idling_on = 1'b1;
   int           mismatches = 0;
   int           items_sent = 0;
   int           settings_written = 0;
   int           unsolvable_seen = 0;

   linear_congruence_solver uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_coefficient_a (req_coefficient_a),
      .req_right_side_b  (req_right_side_b),
      .rsp_valid       (rsp_valid),
      .rsp_solution    (rsp_solution),
      .rsp_no_solution (rsp_no_solution),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic solution_type solve_congruence(input word_type m_in,
                                                     input word_type a_in,
                                                     input word_type b_in);
      logic [63:0] m, a, b;
      logic [63:0] r_old, r_new, r_tmp, s_old, s_new, s_tmp, q, g, magnitude, base;
      solution_type sol;
      m = 64'(m_in) & OPERAND_MASK;
      a = 64'(a_in) & OPERAND_MASK;
      b = 64'(b_in) & OPERAND_MASK;
      sol.solution = '0;
      sol.no_solution = 1'b1;
      if (m == 64'd0)
         return sol;
      r_old = a;
      r_new = m;
      s_old = 64'd1;
      s_new = 64'd0;
      while (r_new != 64'd0) begin
         q = r_old / r_new;
         r_tmp = r_old - q * r_new;
         r_old = r_new;
         r_new = r_tmp;
         s_tmp = s_old - q * s_new;
         s_old = s_new;
         s_new = s_tmp;
      end
      g = r_old;
      if (b % g != 64'd0)
         return sol;
      if (s_old[63]) begin
         magnitude = (-s_old) % m;
         base = (magnitude == 64'd0) ? 64'd0 : m - magnitude;
      end else begin
         base = s_old % m;
      end
      sol.solution = word_type'((base * (b / g)) % m);
      sol.no_solution = 1'b0;
      return sol;
   endfunction

   function automatic word_type pick_modulus();
      case ($urandom_range(0, 9))
         0: return word_type'($urandom);
         1: return word_type'($urandom_range(2, 1000));
         2: return word_type'(32'd1 << $urandom_range(1, 31));
         3: return word_type'(32'd720720 * $urandom_range(1, 5000));
         4: return word_type'(LARGEST_PRIME);
         5: return word_type'($urandom | 32'h8000_0000);
         6: return word_type'($urandom & ~((32'd1 << $urandom_range(1, 16)) - 32'd1));
         7: return word_type'(32'hFFFF_FFFF);
         8: return word_type'($urandom_range(1, 2));
         default: return word_type'($urandom_range(2, 65535));
      endcase
   endfunction

   function automatic word_type pick_multiplier(input word_type m);
      case ($urandom_range(0, 7))
         3: return word_type'($urandom & ~((32'd1 << $urandom_range(1, 20)) - 32'd1));
         4: return word_type'($urandom_range(0, 15));
         5: return m * word_type'($urandom_range(1, 3)) - word_type'($urandom_range(0, 3));
         6: return word_type'(32'hFFFF_FFFF - $urandom_range(0, 3));
         7: return (m / word_type'($urandom_range(1, 8))) * word_type'($urandom_range(1, 8));
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic word_type pick_right_side();
      case ($urandom_range(0, 7))
         4: return word_type'($urandom & ~((32'd1 << $urandom_range(1, 20)) - 32'd1));
         5: return '0;
         6: return word_type'(32'hFFFF_FFFF);
         7: return word_type'($urandom_range(0, 255));
         default: return word_type'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input word_type want,
                                  input word_type got);
      mismatches++;
      $display("mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
   endtask

   task automatic send_item(input word_type a, input word_type b);
      if (idling_on && $urandom_range(0, 3) == 0)
         while (pending_solutions.size() != 0)
            @(posedge clock);
      if (idling_on && $urandom_range(0, 1) == 0)
         repeat ($urandom_range(1, 19)) @(negedge clock);
      @(negedge clock);
      start <= 1'b1;
      req_coefficient_a <= a;
      req_right_side_b <= b;
      do
         @(posedge clock);
      while (busy);
      pending_solutions.push_back(solve_congruence(modulus_shadow, a, b));
      items_sent++;
      @(negedge clock);
      start <= 1'b0;
      if (idling_on && $urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 19)) @(negedge clock);
   endtask

   task automatic write_modulus(input word_type value);
      while (pending_solutions.size() != 0)
         @(posedge clock);
      if (idling_on && $urandom_range(0, 1) == 0)
         repeat ($urandom_range(1, 19)) @(negedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      modulus_shadow = value;
      settings_written++;
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_data <= word_type'($urandom);
   endtask

   task automatic test_reset_modulus();
      send_item(word_type'(32'h1234_5678), word_type'(32'hFFFF_FFFF));
      send_item('0, '0);
   endtask

   task automatic test_zero_modulus();
      write_modulus('0);
      send_item(word_type'(5), word_type'(7));
      send_item('0, '0);
   endtask

   task automatic test_unit_modulus();
      write_modulus(word_type'(1));
      send_item(word_type'(32'hFFFF_FFFF), word_type'(32'hFFFF_FFFF));
   endtask

   task automatic test_operand_extremes();
      write_modulus(word_type'(32'hFFFF_FFFF));
      send_item(word_type'(32'hFFFF_FFFF), '0);
      send_item(word_type'(32'hFFFF_FFFE), word_type'(32'hFFFF_FFFF));
      send_item(word_type'(1), word_type'(1));
      send_item(word_type'(3), word_type'(32'h5555_5555));
      write_modulus(word_type'(32'h8000_0000));
      send_item(word_type'(2), word_type'(3));
      send_item(word_type'(2), word_type'(4));
      send_item(word_type'(32'h8000_0000), word_type'(5));
      send_item(word_type'(32'h7FFF_FFFF), word_type'(32'h8000_0000));
      write_modulus(word_type'(LARGEST_PRIME));
      send_item(word_type'(32'hFFFF_FFFF), word_type'(32'hAAAA_AAAA));
   endtask

   task automatic test_zero_multiplier();
      write_modulus(word_type'(12));
      send_item('0, word_type'(24));
      send_item('0, word_type'(25));
      send_item('0, '0);
      send_item(word_type'(12), word_type'(36));
   endtask

   task automatic test_random_congruences();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_modulus(pick_modulus());
         repeat ($urandom_range(20, 30))
            send_item(pick_multiplier(modulus_shadow), pick_right_side());
      end
   endtask

   task automatic test_steady_stream();
      idling_on = 1'b0;
      repeat (2) begin
         write_modulus(pick_modulus());
         repeat (35)
            send_item(pick_multiplier(modulus_shadow), pick_right_side());
      end
   endtask

   always @(posedge clock) begin
      solution_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_solutions.size() == 0) begin
            report_mismatch("result with nothing pending", '0, rsp_solution);
         end else begin
            want = pending_solutions.pop_front();
            if (want.no_solution)
               unsolvable_seen++;
            if (rsp_solution !== want.solution)
               report_mismatch("solution", want.solution, rsp_solution);
            if (rsp_no_solution !== want.no_solution)
               report_mismatch("no_solution", word_type'(want.no_solution),
                               word_type'(rsp_no_solution));
         end
      end
   end

   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid === 1'b1 || (csr_valid && csr_ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("linear_congruence_solver_tb: errors");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_modulus();
      test_zero_modulus();
      test_unit_modulus();
      test_operand_extremes();
      test_zero_multiplier();
      test_random_congruences();
      test_steady_stream();

      while (pending_solutions.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("solved %0d congruences across %0d modulus writes", items_sent, settings_written);
      $display("%0d of them had no solution, %0d mismatches", unsolvable_seen, mismatches);
      if (mismatches == 0)
         $display("linear_congruence_solver_tb: clean");
      else
         $display("linear_congruence_solver_tb: errors");
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/lcs_pkg.sv
src/lcs_ctrl.sv
src/lcs_dpath.sv
src/linear_congruence_solver.sv
src/lcs_checker.sv
verif/linear_congruence_solver_tb.sv
